[src/sv2seg_pkg.sv]
`default_nettype none

package sv2seg_pkg;

    localparam int MAG_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int POS_W      = 4;
    localparam int CNT_W      = 5;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 16;

    localparam logic [7:0] CH_BLANK  = 8'h20;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_POINT  = 8'h80;
    localparam logic [7:0] SEG_H     = 8'h10;
    localparam logic [6:0] FONT_DASH = 7'h19;
    localparam logic [6:0] FONT_LAST = 7'h1A;

    localparam logic [7:0] FONT [27] = '{
        8'hEE, 8'h60, 8'h2F, 8'h6D, 8'hE1, 8'hCD, 8'hCF, 8'h68, 8'hEF, 8'hED,
        8'hEB, 8'hC7, 8'h8E, 8'h67, 8'h8F, 8'h8B, 8'hCE, 8'hE3, 8'h86, 8'h43,
        8'h47, 8'hAB, 8'h03, 8'h87, 8'h46, 8'h01, 8'h00
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_WRITE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } chain_ctl_t;

    typedef logic [BCD_DIGITS-1:0][3:0] bcd_t;

    function automatic logic [7:0] char_to_seg(input logic [7:0] c);
        logic [6:0] code;
        logic [7:0] seg;
        code = c[6:0];
        if (code >= 7'h30 && code <= 7'h39) begin
            code = code - 7'h30;
        end
        case (code)
            7'h41:        code = 7'h0A;
            7'h62:        code = 7'h0B;
            7'h43:        code = 7'h0C;
            7'h44, 7'h64: code = 7'h0D;
            7'h65:        code = 7'h0E;
            7'h66, 7'h46: code = 7'h0F;
            7'h47:        code = 7'h10;
            7'h48:        code = 7'h11;
            7'h49:        code = 7'h01;
            7'h4C:        code = 7'h12;
            7'h6E:        code = 7'h13;
            7'h4F:        code = 7'h00;
            7'h6F:        code = 7'h14;
            7'h50:        code = 7'h15;
            7'h52, 7'h72: code = 7'h16;
            7'h74:        code = 7'h17;
            7'h75:        code = 7'h18;
            7'h2D:        code = FONT_DASH;
            7'h20:        code = FONT_LAST;
            default:      code = code;
        endcase
        if (code > FONT_LAST) begin
            code = FONT_DASH;
        end
        seg = FONT[code[4:0]];
        if (c[7]) begin
            seg = seg | SEG_H;
        end
        return seg;
    endfunction

endpackage

`default_nettype wire

[src/sv2seg_bcd_cell.sv]
`default_nettype none

module sv2seg_bcd_cell (
    input  wire                     aclk,
    input  wire sv2seg_pkg::chain_ctl_t ctl,
    input  wire                     shift_in,
    output logic                    shift_out,
    output logic [3:0]              digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    always_comb begin
        adj        = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
        digit_next = {adj[2:0], shift_in};
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            digit_reg <= 4'd0;
        end else if (ctl.step) begin
            digit_reg <= digit_next;
        end
    end

    assign shift_out = adj[3];
    assign digit     = digit_reg;

endmodule

`default_nettype wire

[src/sv2seg_bcd_chain.sv]
`default_nettype none

module sv2seg_bcd_chain (
    input  wire                             aclk,
    input  wire sv2seg_pkg::chain_ctl_t     ctl,
    input  wire [sv2seg_pkg::MAG_W-1:0]     mag,
    output sv2seg_pkg::bcd_t                digits
);

    logic [sv2seg_pkg::MAG_W-1:0]      mag_reg;
    logic [sv2seg_pkg::BCD_DIGITS-1:0] carry;

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            mag_reg <= mag;
        end else if (ctl.step) begin
            mag_reg <= {mag_reg[sv2seg_pkg::MAG_W-2:0], 1'b0};
        end
    end

    assign carry[0] = mag_reg[sv2seg_pkg::MAG_W-1];

    for (genvar k = 0; k < sv2seg_pkg::BCD_DIGITS; k++) begin : g_cell
        if (k < sv2seg_pkg::BCD_DIGITS - 1) begin : g_mid
            sv2seg_bcd_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .shift_in  (carry[k]),
                .shift_out (carry[k+1]),
                .digit     (digits[k])
            );
        end else begin : g_top
            sv2seg_bcd_cell u_cell (
                .aclk      (aclk),
                .ctl       (ctl),
                .shift_in  (carry[k]),
                .shift_out (),
                .digit     (digits[k])
            );
        end
    end

endmodule

`default_nettype wire

[src/signed_value_to_seven_segment_display_unit.sv]
// Shows a signed 32-bit value on a row of DIGIT_COUNT seven-segment positions. Each input
// word converts the magnitude to BCD in a row of ten digit cells (one shift per cycle),
// writes the digits into the display store from the start position rightward, then emits
// every position as a segment code, one output word per cycle while m_tready is high, last
// on the rightmost. A new input word is taken only after the last output word of the
// previous item has been loaded into the output register. The store resets to blanks and
// keeps its contents between items.
`default_nettype none

module signed_value_to_seven_segment_display_unit #(
    parameter int DIGIT_COUNT = 10
) (
    input  wire                                  aclk,
    input  wire                                  aresetn,
    input  wire                                  s_tvalid,
    output logic                                 s_tready,
    // value [31:0], start_position [35:32], point_position [39:36]
    input  wire [sv2seg_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  wire                                  m_tready,
    // position [3:0], segments [11:4], zero [15:12]
    output logic [sv2seg_pkg::OUT_DATA_W-1:0]    m_tdata,
    output logic                                 m_tlast
);

    localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int PW    = sv2seg_pkg::POS_W;

    sv2seg_pkg::state_t     state_reg, state_next;
    sv2seg_pkg::chain_ctl_t chain_ctl;
    sv2seg_pkg::bcd_t       digits;

    logic [sv2seg_pkg::CNT_W-1:0] cnt_reg;
    logic [IDX_W-1:0]             emit_idx_reg;
    logic [PW-1:0]                start_reg;
    logic [PW-1:0]                point_reg;
    logic                         neg_reg;

    logic [7:0] store_reg  [DIGIT_COUNT];
    logic [7:0] store_next [DIGIT_COUNT];

    logic                          m_tvalid_reg;
    logic [PW-1:0]                 m_pos_reg;
    logic [7:0]                    m_seg_reg;
    logic                          m_last_reg;

    logic                          s_accept;
    logic                          emit_load;
    logic [31:0]                   in_value;
    logic [sv2seg_pkg::MAG_W-1:0]  in_mag;

    logic [PW-1:0]          start_eff;
    logic [PW-1:0]          s_pos;
    logic [PW-1:0]          p_pos;
    logic                   p_valid;
    logic                   write_ok;
    logic                   over;
    logic [3:0]             pos_digit [DIGIT_COUNT];
    logic [DIGIT_COUNT-1:0] hit;
    logic [DIGIT_COUNT-1:0] started;
    logic [DIGIT_COUNT-1:0] first;

    assign in_value = s_tdata[31:0];
    assign in_mag   = in_value[31] ? (~in_value + 32'd1) : in_value;
    assign s_accept = s_tvalid && s_tready;

    sv2seg_bcd_chain u_chain (
        .aclk   (aclk),
        .ctl    (chain_ctl),
        .mag    (in_mag),
        .digits (digits)
    );

    for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_pos
        if (DIGIT_COUNT - 1 - i < sv2seg_pkg::BCD_DIGITS) begin : g_dig
            assign pos_digit[i] = digits[DIGIT_COUNT - 1 - i];
        end else begin : g_zero
            assign pos_digit[i] = 4'd0;
        end
    end

    always_comb begin
        start_eff = (start_reg == '0) ? PW'(1) : start_reg;
        s_pos     = start_eff - PW'(1);
        write_ok  = ({1'b0, start_eff} <= 5'(DIGIT_COUNT));
        p_valid   = (point_reg != '0) && ({1'b0, point_reg} <= 5'(DIGIT_COUNT));
        p_pos     = point_reg - PW'(1);

        over = 1'b0;
        for (int k = 0; k < sv2seg_pkg::BCD_DIGITS; k++) begin
            if (digits[k] != 4'd0 && ({1'b0, s_pos} + 5'(k) >= 5'(DIGIT_COUNT))) begin
                over = 1'b1;
            end
        end

        for (int i = 0; i < DIGIT_COUNT; i++) begin
            hit[i] = (PW'(i) >= s_pos) &&
                     ((pos_digit[i] != 4'd0) || (p_valid && PW'(i) == p_pos));
        end

        for (int i = 0; i < DIGIT_COUNT; i++) begin
            started[i] = 1'b0;
            for (int j = 0; j <= i; j++) begin
                started[i] = started[i] | hit[j];
            end
        end

        for (int i = 0; i < DIGIT_COUNT; i++) begin
            first[i] = started[i] && !((i > 0) && started[(i > 0) ? i - 1 : 0]);
        end

        for (int i = 0; i < DIGIT_COUNT; i++) begin
            store_next[i] = store_reg[i];
            if (PW'(i) >= s_pos) begin
                if (over) begin
                    store_next[i] = sv2seg_pkg::CH_DASH;
                end else if (started[i]) begin
                    store_next[i] = {4'd0, pos_digit[i]};
                end else begin
                    store_next[i] = sv2seg_pkg::CH_BLANK;
                end
                if (p_valid && PW'(i) == p_pos) begin
                    store_next[i] = store_next[i] | sv2seg_pkg::CH_POINT;
                end
            end
            if (i < DIGIT_COUNT - 1) begin
                if (neg_reg && !over && first[(i < DIGIT_COUNT - 1) ? i + 1 : i]) begin
                    store_next[i] = sv2seg_pkg::CH_DASH;
                end
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        s_tready       = 1'b0;
        chain_ctl.load = 1'b0;
        chain_ctl.step = 1'b0;
        emit_load      = 1'b0;
        case (state_reg)
            sv2seg_pkg::ST_IDLE: begin
                s_tready       = aresetn;
                chain_ctl.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = sv2seg_pkg::ST_CONVERT;
                end
            end
            sv2seg_pkg::ST_CONVERT: begin
                chain_ctl.step = 1'b1;
                if (cnt_reg == sv2seg_pkg::CNT_W'(sv2seg_pkg::MAG_W - 1)) begin
                    state_next = sv2seg_pkg::ST_WRITE;
                end
            end
            sv2seg_pkg::ST_WRITE: begin
                state_next = sv2seg_pkg::ST_EMIT;
            end
            sv2seg_pkg::ST_EMIT: begin
                emit_load = !m_tvalid_reg || m_tready;
                if (emit_load && emit_idx_reg == IDX_W'(DIGIT_COUNT - 1)) begin
                    state_next = sv2seg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sv2seg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sv2seg_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            start_reg <= s_tdata[35:32];
            point_reg <= s_tdata[39:36];
            neg_reg   <= in_value[31];
            cnt_reg   <= '0;
        end else if (state_reg == sv2seg_pkg::ST_CONVERT) begin
            cnt_reg <= cnt_reg + sv2seg_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                store_reg[i] <= sv2seg_pkg::CH_BLANK;
            end
        end else if (state_reg == sv2seg_pkg::ST_WRITE && write_ok) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                store_reg[i] <= store_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            emit_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (state_reg == sv2seg_pkg::ST_WRITE) begin
                emit_idx_reg <= '0;
            end else if (emit_load) begin
                emit_idx_reg <= emit_idx_reg + IDX_W'(1);
            end
            if (emit_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_load) begin
            m_pos_reg  <= PW'(emit_idx_reg);
            m_seg_reg  <= sv2seg_pkg::char_to_seg(store_reg[emit_idx_reg]);
            m_last_reg <= (emit_idx_reg == IDX_W'(DIGIT_COUNT - 1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, m_seg_reg, m_pos_reg};
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire
